@@ sv/dpbp_pkg.sv @@
// ----------------------------------------------------------------------------
// dpbp_pkg
// Shared widths, constants, register indexes and types for the depth pixel
// back-projection block.
// ----------------------------------------------------------------------------
package dpbp_pkg;

    // pixel position counters
    localparam int COORD_BITS  = 12;
    localparam int COORD_LIMIT = 1 << COORD_BITS;

    // field and register widths
    localparam int SIZE_W     = 13;
    localparam int CENTER_W   = 16;
    localparam int INV_W      = 24;
    localparam int DEPTH_W    = 16;
    localparam int POINT_W    = 32;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_ADDR_W = 3;

    // width for frame size compares
    localparam int CMP_W = (SIZE_W > COORD_BITS + 1) ? SIZE_W : COORD_BITS + 1;

    // arithmetic widths of the projection datapath
    localparam int POS_Q4_W    = COORD_BITS + 4;
    localparam int MAG_W       = (POS_Q4_W > CENTER_W) ? POS_Q4_W : CENTER_W;
    localparam int PROD1_W     = MAG_W + DEPTH_W;
    localparam int PROD2_W     = PROD1_W + INV_W;
    localparam int ROUND_SHIFT = 24;
    localparam int QUOT_W      = PROD2_W - ROUND_SHIFT;

    localparam logic [POINT_W-1:0] SAT_POS = {1'b0, {(POINT_W-1){1'b1}}};
    localparam logic [POINT_W-1:0] SAT_NEG = {1'b1, {(POINT_W-1){1'b0}}};

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // back-end pipeline length
    localparam int PIPE_STAGES = 4;

    // register reset values
    localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH  = SIZE_W'(320);
    localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT = SIZE_W'(240);
    localparam logic [CENTER_W-1:0] RST_CENTER_X     = CENTER_W'(2552);
    localparam logic [CENTER_W-1:0] RST_CENTER_Y     = CENTER_W'(1907);
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_X  = INV_W'(55281);
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y  = INV_W'(55281);

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_CENTER_X     = 3'd2,
        REG_CENTER_Y     = 3'd3,
        REG_INV_FOCAL_X  = 3'd4,
        REG_INV_FOCAL_Y  = 3'd5
    } cfg_reg_t;

    // classified pixel as handed from front to back
    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_W-1:0]    depth;
        logic                  point_valid;
        logic                  frame_end;
    } pixel_t;

    // per-pixel data carried alongside the arithmetic
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               point_valid;
        logic               frame_end;
    } side_t;

endpackage

@@ sv/dpbp_front.sv @@
// ----------------------------------------------------------------------------
// dpbp_front
// Accepts depth beats, tracks column and row against the frame size and
// tags each pixel with its position, validity and end of frame.
// ----------------------------------------------------------------------------
module dpbp_front import dpbp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DEPTH_W-1:0] s_depth_mm,
    input  logic [SIZE_W-1:0]  frame_width,
    input  logic [SIZE_W-1:0]  frame_height,
    input  logic               queue_full,
    output logic               push,
    output pixel_t             push_item
);

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [CMP_W-1:0]      width_eff;
    logic [CMP_W-1:0]      height_eff;
    logic                  row_end;
    logic                  last_row;

    // zero acts as one, oversize clips to the counter range
    function automatic logic [CMP_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(size);
        if (size == '0) begin
            return CMP_W'(1);
        end
        if (ext > CMP_W'(COORD_LIMIT)) begin
            return CMP_W'(COORD_LIMIT);
        end
        return ext;
    endfunction

    // position classification
    always_comb begin
        width_eff  = eff_size(frame_width);
        height_eff = eff_size(frame_height);
        row_end    = (CMP_W'(col_reg) + CMP_W'(1)) >= width_eff;
        last_row   = (CMP_W'(row_reg) + CMP_W'(1)) >= height_eff;
    end

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    always_comb begin
        push_item.col         = col_reg;
        push_item.row         = row_reg;
        push_item.depth       = s_depth_mm;
        push_item.point_valid = (s_depth_mm != '0);
        push_item.frame_end   = row_end && last_row;
    end

    // counter advance
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (push) begin
            if (row_end) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + COORD_BITS'(1);
            end else begin
                col_next = col_reg + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ sv/dpbp_queue.sv @@
// ----------------------------------------------------------------------------
// dpbp_queue
// Short first-in first-out queue of classified pixels between the front and
// the back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module dpbp_queue import dpbp_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  pixel_t push_item,
    input  logic   pop,
    output pixel_t pop_item,
    output logic   full,
    output logic   empty
);

    pixel_t                 queue_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = queue_mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // checks
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("queue popped while empty");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + QUEUE_CNT_W'(1)))
        else $error("queue fill level did not follow a lone push");

endmodule

@@ sv/dpbp_axis.sv @@
// ----------------------------------------------------------------------------
// dpbp_axis
// Four-stage back-projection of one axis: centre offset, depth product,
// focal product, then rounding, sign and saturation.
// ----------------------------------------------------------------------------
module dpbp_axis import dpbp_pkg::*; (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [COORD_BITS-1:0] pos,
    input  logic [CENTER_W-1:0]   center,
    input  logic [DEPTH_W-1:0]    depth,
    input  logic [INV_W-1:0]      inv_focal,
    output logic [POINT_W-1:0]    coord
);

    localparam logic [PROD2_W-1:0] ROUND_HALF = PROD2_W'(1) << (ROUND_SHIFT - 1);

    logic [MAG_W-1:0]   pos_q4;
    logic [MAG_W-1:0]   center_ext;
    logic               neg_next;
    logic [MAG_W-1:0]   mag_next;
    logic [PROD1_W-1:0] prod1_next;
    logic [PROD2_W-1:0] prod2_next;
    logic [PROD2_W-1:0] rounded;
    logic [QUOT_W-1:0]  quot;
    logic               over;
    logic [POINT_W-1:0] coord_next;

    logic               neg1_reg, neg2_reg, neg3_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [PROD1_W-1:0] prod1_reg;
    logic [PROD2_W-1:0] prod2_reg;
    logic [POINT_W-1:0] coord_reg;

    // stage one: signed Q.4 offset from the principal point
    always_comb begin
        pos_q4     = MAG_W'({pos, 4'b0000});
        center_ext = MAG_W'(center);
        neg_next   = pos_q4 < center_ext;
        mag_next   = neg_next ? center_ext - pos_q4 : pos_q4 - center_ext;
    end

    // stage two and three: magnitude times depth, then times inverse focal
    assign prod1_next = PROD1_W'(mag_reg) * PROD1_W'(depth_reg);
    assign prod2_next = PROD2_W'(prod1_reg) * PROD2_W'(inv_focal);

    // stage four: round half up on the magnitude, apply sign, saturate
    always_comb begin
        rounded = prod2_reg + ROUND_HALF;
        quot    = rounded[PROD2_W-1:ROUND_SHIFT];
        over    = |quot[QUOT_W-1:POINT_W-1];
        if (neg3_reg) begin
            coord_next = over ? SAT_NEG : POINT_W'(0) - quot[POINT_W-1:0];
        end else begin
            coord_next = over ? SAT_POS : quot[POINT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg  <= neg_next;
            mag_reg   <= mag_next;
            depth_reg <= depth;
            neg2_reg  <= neg1_reg;
            prod1_reg <= prod1_next;
            neg3_reg  <= neg2_reg;
            prod2_reg <= prod2_next;
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

@@ sv/dpbp_back.sv @@
// ----------------------------------------------------------------------------
// dpbp_back
// Drains the pixel queue into a stalling four-stage pipeline that forms the
// x and y coordinates; the last stage is the output register.
// ----------------------------------------------------------------------------
module dpbp_back import dpbp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                queue_empty,
    input  pixel_t              queue_item,
    output logic                pop,
    input  logic [CENTER_W-1:0] center_x,
    input  logic [CENTER_W-1:0] center_y,
    input  logic [INV_W-1:0]    inv_focal_x,
    input  logic [INV_W-1:0]    inv_focal_y,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [POINT_W-1:0]  m_point_x,
    output logic [POINT_W-1:0]  m_point_y,
    output logic [DEPTH_W-1:0]  m_point_z,
    output logic                m_point_valid,
    output logic                m_frame_end
);

    logic                   en;
    logic [PIPE_STAGES-1:0] stg_valid_reg, stg_valid_next;
    side_t                  side_reg [PIPE_STAGES];
    side_t                  side_in;

    // whole pipe moves unless the output beat is held
    assign en  = !stg_valid_reg[PIPE_STAGES-1] || m_ready;
    assign pop = !queue_empty && en;

    assign stg_valid_next = en ? {stg_valid_reg[PIPE_STAGES-2:0], pop} : stg_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= '0;
        end else begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    // depth and flags ride alongside the arithmetic
    always_comb begin
        side_in.depth       = queue_item.depth;
        side_in.point_valid = queue_item.point_valid;
        side_in.frame_end   = queue_item.frame_end;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < PIPE_STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // one projection unit per axis
    dpbp_axis u_axis_x (
        .aclk      (aclk),
        .en        (en),
        .pos       (queue_item.col),
        .center    (center_x),
        .depth     (queue_item.depth),
        .inv_focal (inv_focal_x),
        .coord     (m_point_x)
    );

    dpbp_axis u_axis_y (
        .aclk      (aclk),
        .en        (en),
        .pos       (queue_item.row),
        .center    (center_y),
        .depth     (queue_item.depth),
        .inv_focal (inv_focal_y),
        .coord     (m_point_y)
    );

    // result beat
    assign m_valid       = stg_valid_reg[PIPE_STAGES-1];
    assign m_point_z     = side_reg[PIPE_STAGES-1].depth;
    assign m_point_valid = side_reg[PIPE_STAGES-1].point_valid;
    assign m_frame_end   = side_reg[PIPE_STAGES-1].frame_end;

    // checks
    a_pop_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> stg_valid_reg[0])
        else $error("popped pixel did not enter the pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> (stg_valid_reg == $past(stg_valid_reg)))
        else $error("pipeline moved during an output stall");

endmodule

@@ sv/depth_pixel_back_projection.sv @@
// ----------------------------------------------------------------------------
// depth_pixel_back_projection
// Pinhole back-projection of a raster stream of depth pixels into points,
// with the configuration registers and the front, queue and back parts.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while m_ready does not hold the output beat, set by the four-stage multiply pipeline
// the four-entry queue absorbs short output stalls before s_ready drops
// reset (synchronous, aresetn low): counters, queue and pipeline empty,
// registers back to their default camera settings
module depth_pixel_back_projection import dpbp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DEPTH_W-1:0]    s_depth_mm,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [POINT_W-1:0]    m_point_x,
    output logic [POINT_W-1:0]    m_point_y,
    output logic [DEPTH_W-1:0]    m_point_z,
    output logic                  m_point_valid,
    output logic                  m_frame_end
);

    logic [SIZE_W-1:0]   frame_width_reg;
    logic [SIZE_W-1:0]   frame_height_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [INV_W-1:0]    inv_focal_x_reg;
    logic [INV_W-1:0]    inv_focal_y_reg;

    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_empty;
    pixel_t push_item;
    pixel_t queue_item;

    // configuration registers, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            center_x_reg     <= RST_CENTER_X;
            center_y_reg     <= RST_CENTER_Y;
            inv_focal_x_reg  <= RST_INV_FOCAL_X;
            inv_focal_y_reg  <= RST_INV_FOCAL_Y;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_CENTER_X:     center_x_reg     <= cfg_wdata[CENTER_W-1:0];
                REG_CENTER_Y:     center_y_reg     <= cfg_wdata[CENTER_W-1:0];
                REG_INV_FOCAL_X:  inv_focal_x_reg  <= cfg_wdata[INV_W-1:0];
                REG_INV_FOCAL_Y:  inv_focal_y_reg  <= cfg_wdata[INV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // position tracking and classification
    dpbp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_depth_mm   (s_depth_mm),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .queue_full   (queue_full),
        .push         (push),
        .push_item    (push_item)
    );

    // decoupling queue
    dpbp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (queue_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // projection arithmetic and output register
    dpbp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .queue_empty   (queue_empty),
        .queue_item    (queue_item),
        .pop           (pop),
        .center_x      (center_x_reg),
        .center_y      (center_y_reg),
        .inv_focal_x   (inv_focal_x_reg),
        .inv_focal_y   (inv_focal_y_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_point_z     (m_point_z),
        .m_point_valid (m_point_valid),
        .m_frame_end   (m_frame_end)
    );

endmodule
